>>> src/bau_pkg.sv
package bau_pkg;

   // Field and register widths
   localparam int SCALE_W = 10;
   localparam int TIMER_W = 16;
   localparam int TICK_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LANES      = 4;

   localparam logic [SCALE_W-1:0] SCALE_MAX = 10'd1023;
   localparam logic [TIMER_W-1:0] TIMER_MAX = 16'd65535;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_MODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_DELAY_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_MS    = 3'd5;

   // Lane indexes: left up, left down, right up, right down
   localparam int LANE_LEFT_UP    = 0;
   localparam int LANE_LEFT_DOWN  = 1;
   localparam int LANE_RIGHT_UP   = 2;
   localparam int LANE_RIGHT_DOWN = 3;

   // Reset values of the timing registers
   localparam logic [TICK_W-1:0]  TICK_MS_RST       = 8'd10;
   localparam logic [TIMER_W-1:0] HOLD_DELAY_RST    = 16'd500;
   localparam logic [TIMER_W-1:0] REPEAT_MS_RST     = 16'd100;
   localparam logic [TIMER_W-1:0] RELEASE_DELAY_RST = 16'd250;

   typedef struct packed {
      logic [TICK_W-1:0]  tick_ms;
      logic [TIMER_W-1:0] hold_delay_ms;
      logic [TIMER_W-1:0] repeat_ms;
      logic [TIMER_W-1:0] release_delay_ms;
   } timing_cfg_type;

   typedef struct packed {
      logic step;
      logic save;
   } lane_result_type;

   // Saturating timer advance
   function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] t,
                                                    input logic [TICK_W-1:0] tick);
      logic [TIMER_W:0] sum;
      sum = {1'b0, t} + {{(TIMER_W + 1 - TICK_W){1'b0}}, tick};
      if (sum > {1'b0, TIMER_MAX}) begin
         return TIMER_MAX;
      end
      return sum[TIMER_W-1:0];
   endfunction

   // Step up, saturating at the maximum scale
   function automatic logic [SCALE_W-1:0] scale_inc(input logic [SCALE_W-1:0] lvl);
      if (lvl < SCALE_MAX) begin
         return lvl + 1'b1;
      end
      return SCALE_MAX;
   endfunction

   // Step down, floored at zero
   function automatic logic [SCALE_W-1:0] scale_dec(input logic [SCALE_W-1:0] lvl);
      if (lvl != '0) begin
         return lvl - 1'b1;
      end
      return lvl;
   endfunction

endpackage

>>> src/bau_if.sv
interface bau_req_if;
   logic valid;
   logic ready;
   logic left_up;
   logic left_down;
   logic right_up;
   logic right_down;

   modport source (output valid, output left_up, output left_down,
                   output right_up, output right_down, input ready);
   modport sink   (input valid, input left_up, input left_down,
                   input right_up, input right_down, output ready);
endinterface

interface bau_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bau_pkg::SCALE_W-1:0] left_scale;
   logic [bau_pkg::SCALE_W-1:0] right_scale;
   logic                        save_left;
   logic                        save_right;

   modport source (output valid, output left_scale, output right_scale,
                   output save_left, output save_right, input ready);
   modport sink   (input valid, input left_scale, input right_scale,
                   input save_left, input save_right, output ready);
endinterface

interface bau_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bau_pkg::CSR_IDX_W-1:0]  index;
   logic [bau_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/bau_lane.sv
module bau_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    active,
   input  logic                    pressed,
   input  bau_pkg::timing_cfg_type cfg,
   output bau_pkg::lane_result_type result
);
   import bau_pkg::*;

   logic               held_ff, held_in;
   logic               pending_ff, pending_in;
   logic [TIMER_W-1:0] hold_ff, hold_in;
   logic [TIMER_W-1:0] repeat_ff, repeat_in;
   logic [TIMER_W-1:0] release_ff, release_in;
   logic [TIMER_W-1:0] hold_adv, repeat_adv, release_adv;
   logic               step, save;

   assign hold_adv    = timer_add(hold_ff, cfg.tick_ms);
   assign repeat_adv  = timer_add(repeat_ff, cfg.tick_ms);
   assign release_adv = timer_add(release_ff, cfg.tick_ms);

   // Work out this tick's press, hold and release timing
   always_comb begin
      held_in    = held_ff;
      pending_in = pending_ff;
      hold_in    = hold_ff;
      repeat_in  = repeat_ff;
      release_in = release_ff;
      step       = 1'b0;
      save       = 1'b0;
      if (pressed && !held_ff) begin
         step       = 1'b1;
         held_in    = 1'b1;
         pending_in = 1'b1;
      end else if (pressed) begin
         hold_in = hold_adv;
         if (hold_adv > cfg.hold_delay_ms) begin
            if (repeat_adv > cfg.repeat_ms) begin
               step      = 1'b1;
               repeat_in = '0;
            end else begin
               repeat_in = repeat_adv;
            end
         end
      end else begin
         held_in = 1'b0;
         hold_in = '0;
         if (pending_ff) begin
            if (release_adv > cfg.release_delay_ms) begin
               release_in = '0;
               pending_in = 1'b0;
               save       = 1'b1;
            end else begin
               release_in = release_adv;
            end
         end
      end
   end

   // Drop everything when the lane is idle this tick
   assign result.step = step & active;
   assign result.save = save & active;

   // Advance lane state on each accepted tick while the lane is active
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= 1'b0;
         pending_ff <= 1'b0;
         hold_ff    <= '0;
         repeat_ff  <= '0;
         release_ff <= '0;
      end else if (fire && active) begin
         held_ff    <= held_in;
         pending_ff <= pending_in;
         hold_ff    <= hold_in;
         repeat_ff  <= repeat_in;
         release_ff <= release_in;
      end
   end

endmodule

>>> src/bau_merge.sv
module bau_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  bau_pkg::lane_result_type lane_res [bau_pkg::LANES],
   bau_rsp_if.source                rsp_ch,
   output logic                     out_free
);
   import bau_pkg::*;

   logic [SCALE_W-1:0] left_ff, left_in;
   logic [SCALE_W-1:0] right_ff, right_in;
   logic [SCALE_W-1:0] left_mid, right_mid;
   logic               valid_ff;
   logic               save_l_ff, save_r_ff;

   // Apply up then down for each side
   always_comb begin
      left_mid  = lane_res[LANE_LEFT_UP].step ? scale_inc(left_ff) : left_ff;
      left_in   = lane_res[LANE_LEFT_DOWN].step ? scale_dec(left_mid) : left_mid;
      right_mid = lane_res[LANE_RIGHT_UP].step ? scale_inc(right_ff) : right_ff;
      right_in  = lane_res[LANE_RIGHT_DOWN].step ? scale_dec(right_mid) : right_mid;
   end

   assign out_free = !valid_ff || rsp_ch.ready;

   // Hold scales; the scale registers also serve as the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            left_ff  <= left_in;
            right_ff <= right_in;
            valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Save strobes of the beat
   always_ff @(posedge clock) begin
      if (fire) begin
         save_l_ff <= lane_res[LANE_LEFT_UP].save | lane_res[LANE_LEFT_DOWN].save;
         save_r_ff <= lane_res[LANE_RIGHT_UP].save | lane_res[LANE_RIGHT_DOWN].save;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.left_scale  = left_ff;
   assign rsp_ch.right_scale = right_ff;
   assign rsp_ch.save_left   = save_l_ff;
   assign rsp_ch.save_right  = save_r_ff;

endmodule

>>> src/button_auto_repeat_scale_adjust_top.sv
// A result beat is presented in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle when not stalled; four button lanes update in
//   parallel and one merge stage steps both scales in the same cycle.
// A new tick is taken whenever the result register is empty or being drained.
// Reset (synchronous, active high) clears scales, all lane timers and flags,
//   and loads the configuration defaults; no clearing pass is needed.
module button_auto_repeat_scale_adjust_top (
   input  logic       clock,
   input  logic       reset,
   bau_req_if.sink    req_ch,
   bau_rsp_if.source  rsp_ch,
   bau_csr_if.sink    csr_ch
);
   import bau_pkg::*;

   logic            enable_ff;
   logic            tank_ff;
   timing_cfg_type  cfg_ff;
   logic            fire;
   logic            out_free;
   logic [LANES-1:0] pressed;
   logic [LANES-1:0] active;
   lane_result_type lane_res [LANES];

   // Configuration writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff               <= 1'b0;
         tank_ff                 <= 1'b0;
         cfg_ff.tick_ms          <= TICK_MS_RST;
         cfg_ff.hold_delay_ms    <= HOLD_DELAY_RST;
         cfg_ff.repeat_ms        <= REPEAT_MS_RST;
         cfg_ff.release_delay_ms <= RELEASE_DELAY_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ENABLE:        enable_ff <= csr_ch.data[0];
            CSR_TANK_MODE:     tank_ff <= csr_ch.data[0];
            CSR_TICK_MS:       cfg_ff.tick_ms <= csr_ch.data[TICK_W-1:0];
            CSR_HOLD_DELAY_MS: cfg_ff.hold_delay_ms <= csr_ch.data[TIMER_W-1:0];
            CSR_REPEAT_MS:     cfg_ff.repeat_ms <= csr_ch.data[TIMER_W-1:0];
            CSR_RELEASE_MS:    cfg_ff.release_delay_ms <= csr_ch.data[TIMER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = out_free;
   assign fire         = req_ch.valid && out_free;

   // Gather button levels and lane enables
   always_comb begin
      pressed[LANE_LEFT_UP]    = req_ch.left_up;
      pressed[LANE_LEFT_DOWN]  = req_ch.left_down;
      pressed[LANE_RIGHT_UP]   = req_ch.right_up;
      pressed[LANE_RIGHT_DOWN] = req_ch.right_down;
      active[LANE_LEFT_UP]     = enable_ff;
      active[LANE_LEFT_DOWN]   = enable_ff;
      active[LANE_RIGHT_UP]    = enable_ff && !tank_ff;
      active[LANE_RIGHT_DOWN]  = enable_ff && !tank_ff;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bau_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .fire    (fire),
         .active  (active[g]),
         .pressed (pressed[g]),
         .cfg     (cfg_ff),
         .result  (lane_res[g])
      );
   end

   bau_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .lane_res (lane_res),
      .rsp_ch   (rsp_ch),
      .out_free (out_free)
   );

endmodule

>>> verif/button_auto_repeat_scale_adjust_top_test.sv
module button_auto_repeat_scale_adjust_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bau_pkg::*;

   localparam int IDLE_PCT       = 35;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int STALL_LIMIT    = 1000;
   localparam int SETTLE_CYCLES  = 4;

   typedef struct packed {
      logic [SCALE_W-1:0] left_scale;
      logic [SCALE_W-1:0] right_scale;
      logic               save_left;
      logic               save_right;
   } scale_beat_type;

   // Tracks both scales and the four button lanes, and holds the scale beats still owed
   class scale_scoreboard;
      logic               enable_r;
      logic               tank_r;
      logic [TICK_W-1:0]  tick_r;
      logic [TIMER_W-1:0] hold_delay_r;
      logic [TIMER_W-1:0] repeat_gap_r;
      logic [TIMER_W-1:0] release_delay_r;

      logic [SCALE_W-1:0] left_lvl;
      logic [SCALE_W-1:0] right_lvl;
      logic               held[LANES];
      logic               save_armed[LANES];
      logic [TIMER_W-1:0] hold_t[LANES];
      logic [TIMER_W-1:0] repeat_t[LANES];
      logic [TIMER_W-1:0] release_t[LANES];

      scale_beat_type owed_scales[$];
      int errors;
      int ticks;
      int beats;
      int saves;
      int ceiling_hits;
      int floor_hits;

      function new();
         enable_r        = 1'b0;
         tank_r          = 1'b0;
         tick_r          = 8'd10;
         hold_delay_r    = 16'd500;
         repeat_gap_r    = 16'd100;
         release_delay_r = 16'd250;
         left_lvl        = '0;
         right_lvl       = '0;
         for (int i = 0; i < LANES; i++) begin
            held[i]       = 1'b0;
            save_armed[i] = 1'b0;
            hold_t[i]     = '0;
            repeat_t[i]   = '0;
            release_t[i]  = '0;
         end
         errors       = 0;
         ticks        = 0;
         beats        = 0;
         saves        = 0;
         ceiling_hits = 0;
         floor_hits   = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ENABLE:        enable_r        = val[0];
            CSR_TANK_MODE:     tank_r          = val[0];
            CSR_TICK_MS:       tick_r          = val[TICK_W-1:0];
            CSR_HOLD_DELAY_MS: hold_delay_r    = val[TIMER_W-1:0];
            CSR_REPEAT_MS:     repeat_gap_r    = val[TIMER_W-1:0];
            CSR_RELEASE_MS:    release_delay_r = val[TIMER_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance a timer by one tick, pinned at the top
      function logic [TIMER_W-1:0] advance(input logic [TIMER_W-1:0] t);
         logic [TIMER_W:0] sum;
         sum = {1'b0, t} + {{(TIMER_W + 1 - TICK_W){1'b0}}, tick_r};
         if (sum > {1'b0, {TIMER_W{1'b1}}}) begin
            return {TIMER_W{1'b1}};
         end
         return sum[TIMER_W-1:0];
      endfunction

      // Move one side's scale one step up or down
      function void nudge(input int lane);
         logic [SCALE_W-1:0] lvl;
         logic               left_side;
         left_side = (lane == LANE_LEFT_UP) || (lane == LANE_LEFT_DOWN);
         lvl = left_side ? left_lvl : right_lvl;
         if ((lane == LANE_LEFT_UP) || (lane == LANE_RIGHT_UP)) begin
            if (lvl < {SCALE_W{1'b1}}) begin
               lvl = lvl + 1'b1;
            end
         end else if (lvl != '0) begin
            lvl = lvl - 1'b1;
         end
         if (left_side) begin
            left_lvl = lvl;
         end else begin
            right_lvl = lvl;
         end
      endfunction

      // One lane for one tick; returns one when its release delay runs out
      function logic run_lane(input int lane, input logic pressed);
         if (pressed && !held[lane]) begin
            nudge(lane);
            held[lane]       = 1'b1;
            save_armed[lane] = 1'b1;
         end else if (pressed) begin
            hold_t[lane] = advance(hold_t[lane]);
            if (hold_t[lane] > hold_delay_r) begin
               repeat_t[lane] = advance(repeat_t[lane]);
               if (repeat_t[lane] > repeat_gap_r) begin
                  nudge(lane);
                  repeat_t[lane] = '0;
               end
            end
         end else begin
            held[lane]   = 1'b0;
            hold_t[lane] = '0;
            if (save_armed[lane]) begin
               release_t[lane] = advance(release_t[lane]);
               if (release_t[lane] > release_delay_r) begin
                  release_t[lane]  = '0;
                  save_armed[lane] = 1'b0;
                  return 1'b1;
               end
            end
         end
         return 1'b0;
      endfunction

      function void note_tick(input logic [LANES-1:0] btn);
         scale_beat_type want;
         logic           sl;
         logic           sr;
         sl = 1'b0;
         sr = 1'b0;
         if (enable_r) begin
            sl |= run_lane(LANE_LEFT_UP, btn[LANE_LEFT_UP]);
            sl |= run_lane(LANE_LEFT_DOWN, btn[LANE_LEFT_DOWN]);
            if (!tank_r) begin
               sr |= run_lane(LANE_RIGHT_UP, btn[LANE_RIGHT_UP]);
               sr |= run_lane(LANE_RIGHT_DOWN, btn[LANE_RIGHT_DOWN]);
            end
         end
         want.left_scale  = left_lvl;
         want.right_scale = right_lvl;
         want.save_left   = sl;
         want.save_right  = sr;
         owed_scales.push_back(want);
         ticks++;
      endfunction

      function void check_result(input logic [SCALE_W-1:0] l, input logic [SCALE_W-1:0] r,
                                 input logic sl, input logic sr);
         scale_beat_type want;
         beats++;
         if (owed_scales.size() == 0) begin
            $error("result beat with no tick pending: left_scale %0d right_scale %0d", l, r);
            errors++;
            return;
         end
         want = owed_scales.pop_front();
         if (l !== want.left_scale) begin
            $error("left_scale: expected %0d, actual %0d", want.left_scale, l);
            errors++;
         end
         if (r !== want.right_scale) begin
            $error("right_scale: expected %0d, actual %0d", want.right_scale, r);
            errors++;
         end
         if (sl !== want.save_left) begin
            $error("save_left: expected %0d, actual %0d", want.save_left, sl);
            errors++;
         end
         if (sr !== want.save_right) begin
            $error("save_right: expected %0d, actual %0d", want.save_right, sr);
            errors++;
         end
         if (want.save_left || want.save_right) saves++;
         if (want.left_scale == SCALE_MAX || want.right_scale == SCALE_MAX) ceiling_hits++;
         if (want.left_scale == '0 && want.right_scale == '0) floor_hits++;
      endfunction

      function int pending();
         return owed_scales.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   bau_req_if req_if();
   bau_rsp_if rsp_if();
   bau_csr_if csr_if();

   button_auto_repeat_scale_adjust_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   scale_scoreboard sb = new();

   int idle_pct;
   int rsp_holdoff;
   int stall_cycles;
   int phases_run;

   // Button run lengths: each lane alternates pressed and released runs
   logic [LANES-1:0] lane_level;
   int               run_left[LANES];
   int               up_press_max;
   int               up_rel_max;
   int               dn_press_max;
   int               dn_rel_max;
   int               noise_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Drive result ready: random idling, or a counted hold-off
   always @(negedge clock) begin
      if (rsp_holdoff > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_holdoff = rsp_holdoff - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Check each result beat
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         sb.check_result(rsp_if.left_scale, rsp_if.right_scale,
                         rsp_if.save_left, rsp_if.save_right);
      end
   end

   // Abort when no beat moves on any channel for too long
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles, %0d results owed",
                  stall_cycles, sb.pending());
         $display("[button_auto_repeat_scale_adjust_top] ERROR");
         $finish;
      end
   end

   function automatic logic [LANES-1:0] btns(input logic lu, input logic ld,
                                             input logic ru, input logic rd);
      logic [LANES-1:0] b;
      b[LANE_LEFT_UP]    = lu;
      b[LANE_LEFT_DOWN]  = ld;
      b[LANE_RIGHT_UP]   = ru;
      b[LANE_RIGHT_DOWN] = rd;
      return b;
   endfunction

   task automatic send_tick(input logic [LANES-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.left_up    <= b[LANE_LEFT_UP];
      req_if.left_down  <= b[LANE_LEFT_DOWN];
      req_if.right_up   <= b[LANE_RIGHT_UP];
      req_if.right_down <= b[LANE_RIGHT_DOWN];
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.note_tick(b);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_config(input logic en, input logic tank, input int tick,
                             input int hold, input int rpt, input int rel);
      write_csr(CSR_ENABLE, CSR_DATA_W'(en));
      write_csr(CSR_TANK_MODE, CSR_DATA_W'(tank));
      write_csr(CSR_TICK_MS, CSR_DATA_W'(tick));
      write_csr(CSR_HOLD_DELAY_MS, CSR_DATA_W'(hold));
      write_csr(CSR_REPEAT_MS, CSR_DATA_W'(rpt));
      write_csr(CSR_RELEASE_MS, CSR_DATA_W'(rel));
   endtask

   // Stop offering ticks and wait until every owed result is back
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_runs(input int up_press, input int up_rel, input int dn_press,
                           input int dn_rel, input int noise);
      up_press_max = up_press;
      up_rel_max   = up_rel;
      dn_press_max = dn_press;
      dn_rel_max   = dn_rel;
      noise_pct    = noise;
   endtask

   task automatic pick_buttons(output logic [LANES-1:0] b);
      int  top;
      logic is_up;
      for (int lane = 0; lane < LANES; lane++) begin
         if (run_left[lane] <= 0) begin
            lane_level[lane] = ~lane_level[lane];
            is_up = (lane == LANE_LEFT_UP) || (lane == LANE_RIGHT_UP);
            if (lane_level[lane]) begin
               top = is_up ? up_press_max : dn_press_max;
            end else begin
               top = is_up ? up_rel_max : dn_rel_max;
            end
            run_left[lane] = $urandom_range(top, 1);
         end
         run_left[lane]--;
      end
      b = lane_level;
      if ($urandom_range(99) < noise_pct) begin
         b = LANES'($urandom_range(15));
      end
   endtask

   // Random press/hold/release runs; optional calm stretch and result hold-off
   task automatic run_phase(input int items, input int calm, input int holdoff_at);
      logic [LANES-1:0] b;
      for (int i = 0; i < items; i++) begin
         idle_pct = (i < calm) ? 0 : IDLE_PCT;
         if (i == holdoff_at) rsp_holdoff = HOLDOFF_CYCLES;
         pick_buttons(b);
         send_tick(b);
      end
      idle_pct = IDLE_PCT;
      drain();
      phases_run++;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.left_up    = 1'b0;
      req_if.left_down  = 1'b0;
      req_if.right_up   = 1'b0;
      req_if.right_down = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      idle_pct          = IDLE_PCT;
      rsp_holdoff       = 0;
      stall_cycles      = 0;
      phases_run        = 0;
      lane_level        = '0;
      for (int i = 0; i < LANES; i++) run_left[i] = 0;
      set_runs(12, 12, 12, 12, 10);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Disabled out of reset: presses change nothing
      send_tick(btns(1, 1, 1, 1));
      send_tick(btns(0, 0, 0, 0));
      drain();

      // Directed: floor, press, hold into repeat, release into save, both buttons
      set_config(1'b1, 1'b0, 10, 20, 10, 20);
      send_tick(btns(0, 1, 0, 0));
      send_tick(btns(0, 0, 0, 1));
      send_tick(btns(0, 0, 0, 0));
      send_tick(btns(1, 0, 0, 0));
      repeat (5) send_tick(btns(1, 0, 0, 0));
      repeat (3) send_tick(btns(0, 0, 0, 0));
      send_tick(btns(1, 1, 0, 0));
      send_tick(btns(1, 1, 1, 1));
      repeat (3) send_tick(btns(0, 0, 0, 0));
      drain();

      // Directed: tank mode leaves the right side alone
      set_config(1'b1, 1'b1, 10, 20, 10, 20);
      send_tick(btns(0, 0, 1, 0));
      send_tick(btns(0, 0, 0, 1));
      send_tick(btns(1, 1, 1, 1));
      send_tick(btns(0, 0, 0, 0));
      drain();

      // Directed: zero tick keeps all timers still
      set_config(1'b1, 1'b0, 0, 0, 0, 0);
      send_tick(btns(1, 0, 0, 1));
      send_tick(btns(1, 0, 0, 1));
      send_tick(btns(0, 0, 0, 0));
      drain();

      // Typical timing with a long result hold-off midway
      set_config(1'b1, 1'b0, 10, 40, 20, 30);
      set_runs(12, 12, 12, 12, 10);
      run_phase(200, 0, 50);

      // Ramp both scales into the ceiling; hold and release timers saturate
      set_config(1'b1, 1'b0, 255, 0, 0, 16'hFFFF);
      set_runs(600, 2, 2, 80, 2);
      run_phase(1100, 400, -1);

      // Tank mode, fastest settings, mostly decreasing
      set_config(1'b1, 1'b1, 1, 0, 0, 0);
      set_runs(3, 20, 40, 3, 10);
      run_phase(150, 0, -1);

      // Repeat timer and release timer pinned at the top
      set_config(1'b1, 1'b0, 200, 0, 16'hFFFF, 16'hFFFF);
      set_runs(500, 20, 500, 20, 5);
      run_phase(120, 0, -1);

      // Zero tick with the largest hold delay, then disabled
      set_config(1'b1, 1'b0, 0, 16'hFFFF, 0, 0);
      set_runs(10, 10, 10, 10, 20);
      run_phase(80, 0, -1);
      set_config(1'b0, 1'b0, 10, 20, 10, 20);
      run_phase(80, 0, -1);

      // Random settings
      repeat (3) begin
         set_config(1'b1, 1'($urandom_range(1)), $urandom_range(255, 1), $urandom_range(300),
                    $urandom_range(120), $urandom_range(200));
         set_runs(40, 30, 40, 30, 10);
         run_phase(60, 0, -1);
      end

      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("covered %0d ticks and %0d result beats over %0d random phases",
               sb.ticks, sb.beats, phases_run);
      $display("save strobes on %0d beats, ceiling on %0d, both scales at zero on %0d",
               sb.saves, sb.ceiling_hits, sb.floor_hits);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[button_auto_repeat_scale_adjust_top] OK");
      end else begin
         $display("[button_auto_repeat_scale_adjust_top] ERROR");
      end
      $finish;
   end

endmodule
